[sv/swr_pkg.sv]
`default_nettype none
package swr_pkg;

  localparam int PACKET_BYTES_DEF = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_NODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

  localparam logic [7:0]  SRC_NODE_RST = 8'd1;
  localparam logic [7:0]  OWN_ID_RST   = 8'd2;
  localparam logic [15:0] TIMEOUT_RST  = 16'd1000;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [7:0] NUM_FIRST = 8'd1;
  localparam logic [7:0] NUM_LAST  = 8'd255;
  localparam logic [7:0] BEACON_TAIL = 8'h00;

  localparam int HDR_ID_BYTES = 4;
  localparam int HDR_BYTES    = 7;
  localparam int CHECK_BYTES  = 3;
  localparam int NUM_QUORUM   = 2;

  // burst request from the protocol tracker to the output sequencer
  typedef struct packed {
    logic       beacon;
    logic       header;
    logic       deliver;
    logic [7:0] tail;
  } swr_cmd_t;

endpackage
`default_nettype wire

[sv/swr_in_if.sv]
`default_nettype none
interface swr_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, req_type, rx_byte, input ready);
  modport sink (input valid, req_type, rx_byte, output ready);
endinterface
`default_nettype wire

[sv/swr_out_if.sv]
`default_nettype none
interface swr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ctrl_byte;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, ctrl_byte, data_byte, last, input ready);
  modport sink (input valid, ctrl_byte, data_byte, last, output ready);
endinterface
`default_nettype wire

[sv/swr_ram.sv]
`default_nettype none
module swr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/swr_rx.sv]
`default_nettype none
module swr_rx #(
  parameter int PACKET_BYTES = swr_pkg::PACKET_BYTES_DEF,
  parameter int ADDR_W       = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic              req_type,
  input  wire logic [7:0]        rx_byte,
  input  wire logic [7:0]        src_node,
  input  wire logic [15:0]       timeout,
  output swr_pkg::swr_cmd_t      cmd,
  output logic                   start,
  output logic                   wr_en,
  output logic      [ADDR_W-1:0] wr_addr,
  output logic      [7:0]        wr_data
);
  import swr_pkg::*;

  localparam int PW = $clog2(PACKET_BYTES + 1);

  typedef enum logic [3:0] {
    PH_BEACON    = 4'b0001,
    PH_WAIT      = 4'b0010,
    PH_CHECK_ID  = 4'b0100,
    PH_CHECK_NUM = 4'b1000
  } phase_t;

  phase_t        phase, phase_next, eff_phase;
  logic [1:0]    id_pos, id_pos_next, id_cnt, id_cnt_next;
  logic [1:0]    num_pos, num_pos_next, num_cnt, num_cnt_next;
  logic          in_payload, in_payload_next;
  logic [PW-1:0] ppos, ppos_next, ppos_inc;
  logic [7:0]    expected, expected_next, acked, acked_next;
  logic          ack_sent, ack_sent_next;
  logic [15:0]   elapsed, elapsed_next, elapsed_base, elapsed_inc;
  logic [7:0]    cmp_ref;
  logic          hit, to_wait;
  logic [1:0]    id_sum, num_sum;

  // one byte comparator serves both the id and the packet-number checks
  assign cmp_ref = (phase == PH_CHECK_NUM) ? expected : src_node;
  assign hit     = (rx_byte == cmp_ref);
  assign id_sum  = id_cnt + {1'b0, hit};
  assign num_sum = num_cnt + {1'b0, hit};

  assign eff_phase    = (phase == PH_BEACON) ? PH_WAIT : phase;
  assign elapsed_base = (phase == PH_BEACON) ? 16'd0 : elapsed;
  assign elapsed_inc  = (elapsed_base == 16'hFFFF) ? elapsed_base : elapsed_base + 16'd1;
  assign ppos_inc     = ppos + PW'(1);

  assign wr_addr = ppos[ADDR_W-1:0];
  assign wr_data = rx_byte;
  assign start   = accept && (cmd.beacon || cmd.header || cmd.deliver);

  always_comb begin
    phase_next      = phase;
    id_pos_next     = id_pos;
    id_cnt_next     = id_cnt;
    num_pos_next    = num_pos;
    num_cnt_next    = num_cnt;
    in_payload_next = in_payload;
    ppos_next       = ppos;
    expected_next   = expected;
    acked_next      = acked;
    ack_sent_next   = ack_sent;
    elapsed_next    = elapsed;
    cmd             = '0;
    wr_en           = 1'b0;
    to_wait         = 1'b0;
    if (accept) begin
      if (phase == PH_BEACON) begin
        cmd.beacon   = 1'b1;
        cmd.tail     = BEACON_TAIL;
        phase_next   = PH_WAIT;
        elapsed_next = 16'd0;
      end
      if (req_type == REQ_TICK) begin
        elapsed_next = elapsed_inc;
        if (eff_phase == PH_WAIT && elapsed_inc > timeout) begin
          cmd.header   = 1'b1;
          cmd.tail     = ack_sent ? acked : BEACON_TAIL;
          elapsed_next = 16'd0;
        end
      end else begin
        unique case (eff_phase)
          PH_WAIT: begin
            if (hit) begin
              id_pos_next = 2'd1;
              id_cnt_next = 2'd1;
              phase_next  = PH_CHECK_ID;
            end
          end
          PH_CHECK_ID: begin
            id_pos_next = id_pos + 2'd1;
            id_cnt_next = id_sum;
            if (id_pos + 2'd1 == 2'(CHECK_BYTES)) begin
              id_pos_next = 2'd0;
              id_cnt_next = 2'd0;
              if (id_sum == 2'(CHECK_BYTES)) begin
                phase_next      = PH_CHECK_NUM;
                num_pos_next    = 2'd0;
                num_cnt_next    = 2'd0;
                in_payload_next = 1'b0;
                ppos_next       = '0;
              end else begin
                to_wait = 1'b1;
              end
            end
          end
          PH_CHECK_NUM: begin
            if (in_payload) begin
              wr_en     = 1'b1;
              ppos_next = ppos_inc;
              if (ppos_inc == PW'(PACKET_BYTES)) begin
                cmd.deliver   = 1'b1;
                cmd.tail      = expected;
                acked_next    = expected;
                expected_next = (expected == NUM_LAST) ? NUM_FIRST : expected + 8'd1;
                ack_sent_next = 1'b1;
                to_wait       = 1'b1;
              end
            end else begin
              num_pos_next = num_pos + 2'd1;
              num_cnt_next = num_sum;
              if (num_pos + 2'd1 == 2'(CHECK_BYTES)) begin
                if (num_sum >= 2'(NUM_QUORUM)) begin
                  in_payload_next = 1'b1;
                  ppos_next       = '0;
                end else begin
                  to_wait = 1'b1;
                end
              end
            end
          end
          default: ;
        endcase
      end
      if (to_wait) begin
        id_pos_next     = 2'd0;
        id_cnt_next     = 2'd0;
        num_pos_next    = 2'd0;
        num_cnt_next    = 2'd0;
        in_payload_next = 1'b0;
        ppos_next       = '0;
        phase_next      = PH_WAIT;
        elapsed_next    = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_BEACON;
      id_pos     <= 2'd0;
      id_cnt     <= 2'd0;
      num_pos    <= 2'd0;
      num_cnt    <= 2'd0;
      in_payload <= 1'b0;
      ppos       <= '0;
      expected   <= NUM_FIRST;
      acked      <= NUM_FIRST;
      ack_sent   <= 1'b0;
      elapsed    <= 16'd0;
    end else begin
      phase      <= phase_next;
      id_pos     <= id_pos_next;
      id_cnt     <= id_cnt_next;
      num_pos    <= num_pos_next;
      num_cnt    <= num_cnt_next;
      in_payload <= in_payload_next;
      ppos       <= ppos_next;
      expected   <= expected_next;
      acked      <= acked_next;
      ack_sent   <= ack_sent_next;
      elapsed    <= elapsed_next;
    end
  end

endmodule
`default_nettype wire

[sv/swr_emit.sv]
`default_nettype none
module swr_emit #(
  parameter int PACKET_BYTES = swr_pkg::PACKET_BYTES_DEF,
  parameter int ADDR_W       = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire swr_pkg::swr_cmd_t cmd,
  input  wire logic [7:0]        own_id,
  output logic                   idle,
  output logic                   rd_en,
  output logic      [ADDR_W-1:0] rd_addr,
  input  wire logic [7:0]        rd_data,
  swr_out_if.source              out_ch
);
  import swr_pkg::*;

  localparam int CW = $clog2((PACKET_BYTES > HDR_BYTES) ? PACKET_BYTES : HDR_BYTES);

  typedef enum logic [4:0] {
    SEG_IDLE    = 5'b00001,
    SEG_BEACON  = 5'b00010,
    SEG_MARKER  = 5'b00100,
    SEG_PAYLOAD = 5'b01000,
    SEG_HEADER  = 5'b10000
  } seg_t;

  seg_t          seg, seg_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [7:0]    tail;
  logic          more_hdr;
  logic          adv;
  logic          hdr_end;
  logic [7:0]    ctrl_next, data_next;
  logic          last_next;

  assign idle    = (seg == SEG_IDLE);
  assign adv     = !idle && (!out_ch.valid || out_ch.ready);
  assign hdr_end = (cnt == CW'(HDR_BYTES - 1));

  always_comb begin
    seg_next  = seg;
    cnt_next  = cnt;
    ctrl_next = 8'd0;
    data_next = 8'd0;
    last_next = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    if (start) begin
      cnt_next = '0;
      if (cmd.beacon) begin
        seg_next = SEG_BEACON;
      end else if (cmd.header) begin
        seg_next = SEG_HEADER;
      end else begin
        seg_next = SEG_MARKER;
      end
    end else if (adv) begin
      cnt_next = cnt + CW'(1);
      unique case (seg)
        SEG_BEACON: begin
          ctrl_next = (cnt < CW'(HDR_ID_BYTES)) ? own_id : BEACON_TAIL;
          last_next = hdr_end && !more_hdr;
          if (hdr_end) begin
            cnt_next = '0;
            seg_next = more_hdr ? SEG_HEADER : SEG_IDLE;
          end
        end
        SEG_HEADER: begin
          ctrl_next = (cnt < CW'(HDR_ID_BYTES)) ? own_id : tail;
          last_next = hdr_end;
          if (hdr_end) begin
            cnt_next = '0;
            seg_next = SEG_IDLE;
          end
        end
        SEG_MARKER: begin
          data_next = own_id;
          rd_en     = 1'b1;
          cnt_next  = '0;
          seg_next  = SEG_PAYLOAD;
        end
        SEG_PAYLOAD: begin
          data_next = rd_data;
          if (cnt == CW'(PACKET_BYTES - 1)) begin
            cnt_next = '0;
            seg_next = SEG_HEADER;
          end else begin
            // prefetch the next stored byte; the read data holds while stalled
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(cnt + CW'(1));
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg          <= SEG_IDLE;
      cnt          <= '0;
      more_hdr     <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      seg <= seg_next;
      cnt <= cnt_next;
      if (start) begin
        more_hdr <= cmd.header;
      end
      if (adv) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      tail <= cmd.tail;
    end
    if (adv) begin
      out_ch.ctrl_byte <= ctrl_next;
      out_ch.data_byte <= data_next;
      out_ch.last      <= last_next;
    end
  end

endmodule
`default_nettype wire

[sv/stop_and_wait_packet_receiver_top.sv]
// Receiver end of a stop-and-wait link.
// in_ch carries one item per handshake: a received byte (req_type 0) or one
// time tick (req_type 1). out_ch carries result items (ctrl_byte, data_byte,
// last); last marks the final result caused by one input item.
// An item that causes no result leaves in_ch.ready high, so such items
// stream back to back. A burst item first sets the sequencer state, then
// its results enter the output register one per cycle unless out_ch stalls:
// 7 for a beacon or ack, 14 for a beacon plus an immediate timeout resend,
// PACKET_BYTES + 8 for a packet delivery. in_ch.ready stays low until the
// output sequencer has produced the last result of the burst; it may rise
// while that result still waits in the output register.
// A stall on out_ch freezes the sequencer and the payload memory read;
// nothing is lost or repeated.
// Reset (synchronous) loads the registers with source id 1, own id 2 and
// timeout 1000, empties the output register and arms the startup beacon,
// sent ahead of the results of the first item. The user must write the
// registers through cfg_we/cfg_index/cfg_data while idle (not enforced).
`default_nettype none
module stop_and_wait_packet_receiver_top #(
  parameter int PACKET_BYTES = swr_pkg::PACKET_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [swr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [swr_pkg::CFG_DATA_W-1:0]   cfg_data,
  swr_in_if.sink                                in_ch,
  swr_out_if.source                             out_ch
);
  import swr_pkg::*;

  localparam int ADDR_W = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;

  logic [7:0]        src_node, own_id;
  logic [15:0]       timeout;
  logic              accept, start, idle;
  swr_cmd_t          cmd;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        wr_data, rd_data;

  assign in_ch.ready = idle;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_node <= SRC_NODE_RST;
      own_id   <= OWN_ID_RST;
      timeout  <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_NODE: src_node <= cfg_data[7:0];
        CFG_OWN_ID:   own_id   <= cfg_data[7:0];
        CFG_TIMEOUT:  timeout  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  swr_rx #(
    .PACKET_BYTES(PACKET_BYTES),
    .ADDR_W      (ADDR_W)
  ) u_rx (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .req_type(in_ch.req_type),
    .rx_byte (in_ch.rx_byte),
    .src_node(src_node),
    .timeout (timeout),
    .cmd     (cmd),
    .start   (start),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  swr_ram #(
    .WIDTH (8),
    .DEPTH (PACKET_BYTES),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  swr_emit #(
    .PACKET_BYTES(PACKET_BYTES),
    .ADDR_W      (ADDR_W)
  ) u_emit (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .own_id (own_id),
    .idle   (idle),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
